[hw/rtl/lnps_pkg.sv]
// Package for the last-note-priority stack core.
// Holds the action codes, the controller state type and the cell control struct.
// No dependencies.
package lnps_pkg;

    localparam int NOTE_W   = 8;
    localparam int ACTION_W = 2;

    localparam logic [ACTION_W-1:0] ACT_STOP     = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_PLAY     = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_OVERFLOW = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_OUT0,
        ST_OUT1
    } t_state;

    typedef struct packed {
        logic              press;
        logic              release_en;
        logic [NOTE_W-1:0] note;
    } t_cell_ctl;

endpackage

[hw/rtl/lnps_cell.sv]
// One stack cell: holds a single note and shifts toward or away from the top.
// Depends on lnps_pkg for the cell control struct.
module lnps_cell
    import lnps_pkg::*;
(
    input  logic              i_clk,
    input  t_cell_ctl         i_ctl,
    input  logic              i_press_sel,
    input  logic              i_release_sel,
    input  logic              i_occ,
    input  logic [NOTE_W-1:0] i_prev_note,
    input  logic [NOTE_W-1:0] i_next_note,
    output logic [NOTE_W-1:0] o_note,
    output logic              o_hit
);

    logic [NOTE_W-1:0] r_note;

    always_ff @(posedge i_clk) begin
        if (i_ctl.press && i_press_sel) begin
            r_note <= i_prev_note;
        end else if (i_ctl.release_en && i_release_sel) begin
            r_note <= i_next_note;
        end
    end

    assign o_note = r_note;
    assign o_hit  = i_occ && (r_note == i_ctl.note);

endmodule

[hw/rtl/last_note_priority_stack_core.sv]
// Events are registered on acceptance and executed on the stack of cells in ST_EXEC, all
// cells updating together; result beats go out in ST_OUT0/ST_OUT1, each waiting while the
// output is stalled. o_stall refuses a new event until the current event is done.
// Reset is synchronous and active low; it empties the stack and clears the output valid.
// Cell contents are not reset; only cells below the held count are ever read.
module last_note_priority_stack_core
    import lnps_pkg::*;
#(
    parameter int STACK_DEPTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic                i_op,
    input  logic [NOTE_W-1:0]   i_note,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [ACTION_W-1:0] o_action,
    output logic [NOTE_W-1:0]   o_note_out,
    output logic                o_last
);

    localparam int CW = $clog2(STACK_DEPTH + 1);

    t_state r_state, n_state;

    logic              r_op;
    logic [NOTE_W-1:0] r_note;
    logic [CW-1:0]     r_count, n_count;

    logic [ACTION_W-1:0] r_res0_action, n_res0_action;
    logic [NOTE_W-1:0]   r_res0_note, n_res0_note;
    logic                r_res0_last, n_res0_last;
    logic [ACTION_W-1:0] r_res1_action, n_res1_action;
    logic [NOTE_W-1:0]   r_res1_note, n_res1_note;
    logic                r_two, n_two;

    logic                r_out_valid;
    logic [ACTION_W-1:0] r_out_action;
    logic [NOTE_W-1:0]   r_out_note;
    logic                r_out_last;

    t_cell_ctl                          cell_ctl;
    logic [STACK_DEPTH-1:0]             hit;
    logic [STACK_DEPTH-1:0]             occ;
    logic [STACK_DEPTH-1:0]             press_sel;
    logic [STACK_DEPTH-1:0]             release_sel;
    logic [STACK_DEPTH-1:0][NOTE_W-1:0] cell_note;

    logic any_hit;
    logic full;
    logic slot_free;
    logic load_res0;
    logic load_res1;
    logic in_accept;

    assign any_hit   = |hit;
    assign full      = (r_count == CW'(STACK_DEPTH));
    assign slot_free = !r_out_valid || !i_stall;
    assign in_accept = i_valid && (r_state == ST_IDLE);

    genvar j;
    generate
        for (j = 0; j < STACK_DEPTH; j++) begin : g_cell
            logic [NOTE_W-1:0] prev_note;
            logic [NOTE_W-1:0] next_note;

            assign occ[j]         = (r_count > CW'(j));
            assign press_sel[j]   = !any_hit || (|(hit >> j));
            assign release_sel[j] = |(hit << (STACK_DEPTH - 1 - j));

            if (j == 0) begin : g_top
                assign prev_note = r_note;
            end else begin : g_mid
                assign prev_note = cell_note[j-1];
            end

            if (j == STACK_DEPTH - 1) begin : g_bottom
                assign next_note = cell_note[j];
            end else begin : g_inner
                assign next_note = cell_note[j+1];
            end

            lnps_cell u_cell (
                .i_clk        (i_clk),
                .i_ctl        (cell_ctl),
                .i_press_sel  (press_sel[j]),
                .i_release_sel(release_sel[j]),
                .i_occ        (occ[j]),
                .i_prev_note  (prev_note),
                .i_next_note  (next_note),
                .o_note       (cell_note[j]),
                .o_hit        (hit[j])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state            = r_state;
        n_count            = r_count;
        n_res0_action      = r_res0_action;
        n_res0_note        = r_res0_note;
        n_res0_last        = r_res0_last;
        n_res1_action      = r_res1_action;
        n_res1_note        = r_res1_note;
        n_two              = r_two;
        cell_ctl.press      = 1'b0;
        cell_ctl.release_en = 1'b0;
        cell_ctl.note       = r_note;
        load_res0          = 1'b0;
        load_res1          = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state       = ST_OUT0;
                n_two         = 1'b0;
                n_res1_action = ACT_PLAY;
                n_res1_note   = r_note;
                if (r_op) begin
                    if (!any_hit && full) begin
                        n_res0_action = ACT_OVERFLOW;
                        n_res0_note   = r_note;
                        n_res0_last   = 1'b1;
                    end else begin
                        cell_ctl.press = 1'b1;
                        n_count        = r_count + CW'(!any_hit);
                        if (r_count != '0) begin
                            n_res0_action = ACT_STOP;
                            n_res0_note   = cell_note[0];
                            n_res0_last   = 1'b0;
                            n_two         = 1'b1;
                        end else begin
                            n_res0_action = ACT_PLAY;
                            n_res0_note   = r_note;
                            n_res0_last   = 1'b1;
                        end
                    end
                end else if (any_hit) begin
                    cell_ctl.release_en = 1'b1;
                    n_count             = r_count - CW'(1);
                    n_res0_action       = ACT_STOP;
                    n_res0_note         = r_note;
                    n_res1_note         = cell_note[1];
                    if (!hit[0]) begin
                        n_state = ST_IDLE;
                    end else if (r_count > CW'(1)) begin
                        n_res0_last = 1'b0;
                        n_two       = 1'b1;
                    end else begin
                        n_res0_last = 1'b1;
                    end
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_OUT0: begin
                if (slot_free) begin
                    load_res0 = 1'b1;
                    n_state   = r_two ? ST_OUT1 : ST_IDLE;
                end
            end
            ST_OUT1: begin
                if (slot_free) begin
                    load_res1 = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (load_res0 || load_res1) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_op   <= i_op;
            r_note <= i_note;
        end
        r_res0_action <= n_res0_action;
        r_res0_note   <= n_res0_note;
        r_res0_last   <= n_res0_last;
        r_res1_action <= n_res1_action;
        r_res1_note   <= n_res1_note;
        r_two         <= n_two;
        if (load_res0) begin
            r_out_action <= r_res0_action;
            r_out_note   <= r_res0_note;
            r_out_last   <= r_res0_last;
        end else if (load_res1) begin
            r_out_action <= r_res1_action;
            r_out_note   <= r_res1_note;
            r_out_last   <= 1'b1;
        end
    end

    assign o_stall    = (r_state != ST_IDLE);
    assign o_valid    = r_out_valid;
    assign o_action   = r_out_action;
    assign o_note_out = r_out_note;
    assign o_last     = r_out_last;

endmodule
